[src/bms_pkg.sv]
// Package with the shared constants, a type and a helper function of the byte search block.
package bms_pkg;

  localparam int TEXT_DEPTH = 65536;
  localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
  localparam int FILL_W     = TEXT_AW + 1;
  localparam int PAT_MAX    = 32;
  localparam int PAT_IW     = 5;
  localparam int LEN_W      = 6;
  localparam int SYMBOLS    = 256;
  localparam int SYM_W      = 8;
  localparam int SHIFT_W    = 6;
  localparam int OFFSET_W   = 16;
  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = 64;

  localparam logic [CFG_IW-1:0] CFG_PAT0 = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PAT1 = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_PAT2 = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_PAT3 = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_LEN  = 3'd4;

  // Write request from the table builder into the bad-character memory.
  typedef struct packed {
    logic               we;
    logic [SYM_W-1:0]   addr;
    logic [SHIFT_W-1:0] data;
  } bc_wr_t;

  function automatic logic [7:0] pbyte(input logic [8*PAT_MAX-1:0] pat,
                                       input logic [PAT_IW-1:0] k);
    return pat[k*8 +: 8];
  endfunction

endpackage

[src/bms_if.sv]
// Handshake interfaces for the text byte channel and the search result channel.
interface bms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface bms_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_offset;
  logic        overflow;
  modport source (output valid, output found, output match_offset, output overflow,
                  input ready);
  modport sink (input valid, input found, input match_offset, input overflow,
                output ready);
endinterface

[src/boyer_moore_byte_search.sv]
// Top level of the Boyer-Moore byte search: text loading, configuration and the scan.
//
//  Channel   Direction  Payload                                  Transfer
//  in_ch     sink       text_byte[7:0], last_byte                valid & ready
//  out_ch    source     found, match_offset[15:0], overflow      valid & ready
//  cfg_*     sink       cfg_index[2:0], cfg_data[63:0]           cfg_we
//
// Text bytes are taken one per cycle into the text memory while the block is loading.
// After the request that carries last_byte, the table build presets the bad-character memory,
// enters the pattern bytes and then runs the good-suffix passes.
// The scan reads each text byte in S_READ and compares it in S_CMP; a mismatch adds S_SHIFT,
// as the text and bad-character memories both have registered read data.
// Reset is synchronous and active low; the text memory needs no clearing pass.
// A result waits in its output register; a later result waits in S_DONE until out_ch.ready.
module boyer_moore_byte_search (
  input  logic                        clk,
  input  logic                        rst_n,
  bms_in_if.sink                      in_ch,
  bms_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [bms_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bms_pkg::CFG_DW-1:0]  cfg_data
);

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_BUILD = 6'b000010,
    S_READ  = 6'b000100,
    S_CMP   = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [bms_pkg::CFG_DW-1:0]        pat_r [4];
  logic [bms_pkg::LEN_W-1:0]         plen_r;
  logic [bms_pkg::LEN_W-1:0]         len;
  logic [8*bms_pkg::PAT_MAX-1:0]     pat;
  logic [bms_pkg::FILL_W-1:0]        fill_r, fill_nxt;
  logic                              drop_r, drop_nxt;
  logic [bms_pkg::FILL_W-1:0]        scan_r, scan_nxt;
  logic [bms_pkg::LEN_W-1:0]         pp_r, pp_nxt;
  logic                              found_r, found_nxt;
  logic [bms_pkg::OFFSET_W-1:0]      off_r, off_nxt;
  logic                              res_found_r, res_over_r;
  logic [bms_pkg::OFFSET_W-1:0]      res_off_r;
  logic                              out_valid_r;
  logic                              in_acc, out_acc, out_load;
  logic                              txt_we;
  logic [7:0]                        txt_rdata;
  logic [bms_pkg::SHIFT_W-1:0]       bc_rdata, gs_val, shift;
  logic                              build_start, build_done;
  bms_pkg::bc_wr_t                   bc_wr;

  assign pat = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};
  // Lengths above the pattern capacity saturate to it.
  assign len = (plen_r > bms_pkg::LEN_W'(bms_pkg::PAT_MAX)) ?
               bms_pkg::LEN_W'(bms_pkg::PAT_MAX) : plen_r;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign txt_we      = in_acc && (fill_r < bms_pkg::FILL_W'(bms_pkg::TEXT_DEPTH));
  assign build_start = in_acc && in_ch.last_byte && (len != '0);
  assign shift       = (bc_rdata > gs_val) ? bc_rdata : gs_val;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = res_found_r;
  assign out_ch.match_offset = res_off_r;
  assign out_ch.overflow     = res_over_r;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r[0] <= '0;
      pat_r[1] <= '0;
      pat_r[2] <= '0;
      pat_r[3] <= '0;
      plen_r   <= bms_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bms_pkg::CFG_PAT0: pat_r[0] <= cfg_data;
        bms_pkg::CFG_PAT1: pat_r[1] <= cfg_data;
        bms_pkg::CFG_PAT2: pat_r[2] <= cfg_data;
        bms_pkg::CFG_PAT3: pat_r[3] <= cfg_data;
        bms_pkg::CFG_LEN:  plen_r   <= cfg_data[bms_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    drop_nxt  = drop_r;
    scan_nxt  = scan_r;
    pp_nxt    = pp_r;
    found_nxt = found_r;
    off_nxt   = off_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (txt_we) begin
            fill_nxt = fill_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_ch.last_byte) begin
            if (len == '0) begin
              // The empty pattern matches at the start of the text.
              found_nxt = 1'b1;
              off_nxt   = '0;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_BUILD;
            end
          end
        end
      end
      S_BUILD: begin
        if (build_done) begin
          scan_nxt  = bms_pkg::FILL_W'(len - 1'b1);
          pp_nxt    = len - 1'b1;
          found_nxt = 1'b0;
          off_nxt   = '0;
          // A text shorter than the pattern cannot hold a match.
          state_nxt = (bms_pkg::FILL_W'(len - 1'b1) < fill_r) ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (txt_rdata == bms_pkg::pbyte(pat, pp_r[bms_pkg::PAT_IW-1:0])) begin
          if (pp_r == '0) begin
            found_nxt = 1'b1;
            off_nxt   = scan_r[bms_pkg::OFFSET_W-1:0];
            state_nxt = S_DONE;
          end else begin
            scan_nxt  = scan_r - 1'b1;
            pp_nxt    = pp_r - 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        scan_nxt = scan_r + bms_pkg::FILL_W'(shift);
        pp_nxt   = len - 1'b1;
        state_nxt = (scan_nxt < fill_r) ? S_READ : S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      scan_r      <= '0;
      pp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
      scan_r  <= scan_nxt;
      pp_r    <= pp_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
    found_r <= found_nxt;
    off_r   <= off_nxt;
    if (out_load) begin
      res_found_r <= found_r;
      res_off_r   <= off_r;
      res_over_r  <= drop_r;
    end
  end

  bms_ram #(
    .WIDTH (8),
    .DEPTH (bms_pkg::TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (fill_r[bms_pkg::TEXT_AW-1:0]),
    .wdata (in_ch.text_byte),
    .raddr (scan_r[bms_pkg::TEXT_AW-1:0]),
    .rdata (txt_rdata)
  );

  // The bad-character memory is addressed by the text byte read for the compare.
  bms_ram #(
    .WIDTH (bms_pkg::SHIFT_W),
    .DEPTH (bms_pkg::SYMBOLS)
  ) u_bc_ram (
    .clk   (clk),
    .we    (bc_wr.we),
    .waddr (bc_wr.addr),
    .wdata (bc_wr.data),
    .raddr (txt_rdata),
    .rdata (bc_rdata)
  );

  bms_tables u_tables (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (build_start),
    .len    (len),
    .pat    (pat),
    .done   (build_done),
    .bc_wr  (bc_wr),
    .gs_idx (pp_r[bms_pkg::PAT_IW-1:0]),
    .gs_val (gs_val)
  );

  a_offset_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.match_offset == '0)
    else $error("match offset nonzero on a not-found result");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= bms_pkg::FILL_W'(bms_pkg::TEXT_DEPTH))
    else $error("fill count beyond text capacity");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("search state not one-hot");

  a_new_text_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> fill_r == '0 && !drop_r)
    else $error("text not cleared after result");

  a_scan_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> scan_r < fill_r)
    else $error("scan reads beyond stored text");

endmodule

[src/bms_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module bms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bms_tables.sv]
// Sequencer that builds the bad-character and good-suffix shift tables from the pattern.
module bms_tables (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [bms_pkg::LEN_W-1:0]       len,
  input  logic [8*bms_pkg::PAT_MAX-1:0]   pat,
  output logic                            done,
  output bms_pkg::bc_wr_t                 bc_wr,
  input  logic [bms_pkg::PAT_IW-1:0]      gs_idx,
  output logic [bms_pkg::SHIFT_W-1:0]     gs_val
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_BCALL = 5'b00010,
    B_BCPAT = 5'b00100,
    B_PFX   = 5'b01000,
    B_SUF   = 5'b10000
  } bstate_t;

  bstate_t                        state_r, state_nxt;
  logic [bms_pkg::SYM_W-1:0]      i_r, i_nxt;
  logic [bms_pkg::LEN_W-1:0]      p_r, p_nxt;
  logic [bms_pkg::LEN_W-1:0]      k_r, k_nxt;
  logic [bms_pkg::LEN_W-1:0]      lp_r, lp_nxt;
  logic [bms_pkg::SHIFT_W-1:0]    gs_r [bms_pkg::PAT_MAX];
  logic                           gs_we;
  logic [bms_pkg::PAT_IW-1:0]     gs_wa;
  logic [bms_pkg::SHIFT_W-1:0]    gs_wd;
  logic [bms_pkg::LEN_W:0]        q;
  logic [bms_pkg::LEN_W-1:0]      lp;
  logic [bms_pkg::LEN_W-1:0]      lm1;
  logic [bms_pkg::LEN_W-1:0]      tail;

  assign lm1    = len - 1'b1;
  assign gs_val = gs_r[gs_idx];

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    lp_nxt    = lp_r;
    done      = 1'b0;
    bc_wr     = '0;
    gs_we     = 1'b0;
    gs_wa     = '0;
    gs_wd     = '0;
    q         = '0;
    lp        = lp_r;
    tail      = lm1 - k_r;
    unique case (state_r)
      B_IDLE: begin
        if (start) begin
          state_nxt = B_BCALL;
          i_nxt     = '0;
        end
      end
      B_BCALL: begin
        bc_wr.we   = 1'b1;
        bc_wr.addr = i_r;
        bc_wr.data = len;
        i_nxt      = i_r + 1'b1;
        if (i_r == '1) begin
          i_nxt  = '0;
          p_nxt  = lm1;
          k_nxt  = '0;
          lp_nxt = lm1;
          state_nxt = (len > 6'd1) ? B_BCPAT : B_PFX;
        end
      end
      B_BCPAT: begin
        // Later pattern positions overwrite earlier ones, as the sweep runs upward.
        bc_wr.we   = 1'b1;
        bc_wr.addr = bms_pkg::pbyte(pat, i_r[bms_pkg::PAT_IW-1:0]);
        bc_wr.data = lm1 - i_r[bms_pkg::LEN_W-1:0];
        i_nxt      = i_r + 1'b1;
        if (i_r[bms_pkg::LEN_W-1:0] == len - 6'd2) begin
          state_nxt = B_PFX;
        end
      end
      B_PFX: begin
        // Test whether the pattern tail from p+1 is also a pattern prefix, one byte a cycle.
        q = {1'b0, p_r} + 7'd1 + {1'b0, k_r};
        if (q >= {1'b0, len} ||
            bms_pkg::pbyte(pat, k_r[bms_pkg::PAT_IW-1:0]) !=
            bms_pkg::pbyte(pat, q[bms_pkg::PAT_IW-1:0])) begin
          if (q >= {1'b0, len}) begin
            lp = p_r + 1'b1;
          end
          lp_nxt = lp;
          gs_we  = 1'b1;
          gs_wa  = p_r[bms_pkg::PAT_IW-1:0];
          gs_wd  = lp + (lm1 - p_r);
          k_nxt  = '0;
          if (p_r == '0) begin
            if (len > 6'd1) begin
              state_nxt = B_SUF;
            end else begin
              state_nxt = B_IDLE;
              done      = 1'b1;
            end
          end else begin
            p_nxt = p_r - 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      B_SUF: begin
        // k_r counts the common suffix length at position p.
        if (k_r < p_r &&
            bms_pkg::pbyte(pat, p_r[bms_pkg::PAT_IW-1:0] - k_r[bms_pkg::PAT_IW-1:0]) ==
            bms_pkg::pbyte(pat, tail[bms_pkg::PAT_IW-1:0])) begin
          k_nxt = k_r + 1'b1;
        end else begin
          if (bms_pkg::pbyte(pat, p_r[bms_pkg::PAT_IW-1:0] - k_r[bms_pkg::PAT_IW-1:0]) !=
              bms_pkg::pbyte(pat, tail[bms_pkg::PAT_IW-1:0])) begin
            gs_we = 1'b1;
            gs_wa = tail[bms_pkg::PAT_IW-1:0];
            gs_wd = lm1 - p_r + k_r;
          end
          k_nxt = '0;
          if (p_r == len - 6'd2) begin
            state_nxt = B_IDLE;
            done      = 1'b1;
          end else begin
            p_nxt = p_r + 1'b1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r  <= i_nxt;
    p_r  <= p_nxt;
    k_r  <= k_nxt;
    lp_r <= lp_nxt;
    if (gs_we) begin
      gs_r[gs_wa] <= gs_wd;
    end
  end

endmodule

[dv/bms_tb_if.sv]
// Note: the channel interfaces come from the RTL (src/bms_if.sv); this file holds the testbench's shared typedefs.
`timescale 1ns / 1ps
package bms_tb_pkg;
  // One text byte request and one search result as the testbench sees them.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_offset;
    logic        overflow;
  } search_res_t;
endpackage

[dv/boyer_moore_byte_search_tb.sv]
// Testbench top for the Boyer-Moore byte search: texts are searched against a software scan.
`timescale 1ns / 1ps
module boyer_moore_byte_search_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bms_pkg::CFG_IW-1:0] cfg_index = bms_pkg::CFG_PAT0;
  logic [bms_pkg::CFG_DW-1:0] cfg_data = '0;

  bms_in_if  in_ch();
  bms_out_if out_ch();

  boyer_moore_byte_search uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the configuration and of the text collected so far.
  logic [8*bms_pkg::PAT_MAX-1:0] pat_shadow = '0;
  logic [5:0] len_shadow = 6'd1;
  logic [7:0] text_shadow[$];
  bit dropped_shadow = 1'b0;

  bms_tb_pkg::text_req_t pending_reqs[$];
  bms_tb_pkg::search_res_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int found_seen = 0;
  int overflow_seen = 0;
  int idle_cycles = 0;
  bit gen_done = 1'b0;
  bit hold_sender = 1'b0;
  // Set by the monitor at each rising edge at which a request went in.
  bit in_took = 1'b0;

  // Straightforward leftmost-occurrence search; it must agree with the block's
  // Boyer-Moore scan, which only changes how fast the match is found.
  function automatic bms_tb_pkg::search_res_t search_text();
    bms_tb_pkg::search_res_t r;
    int len, n, hit;
    bit ok;
    len = (len_shadow > bms_pkg::PAT_MAX) ? bms_pkg::PAT_MAX : len_shadow;
    n = text_shadow.size();
    hit = -1;
    if (len == 0) begin
      hit = 0;
    end else begin
      for (int s = 0; s + len <= n && hit < 0; s++) begin
        ok = 1'b1;
        for (int k = 0; k < len && ok; k++) begin
          if (text_shadow[s+k] != pat_shadow[8*k +: 8]) ok = 1'b0;
        end
        if (ok) hit = s;
      end
    end
    r.found = (hit >= 0);
    r.match_offset = (hit >= 0) ? hit[15:0] : 16'd0;
    r.overflow = dropped_shadow;
    return r;
  endfunction

  // Every accepted request updates the shadow text; a last byte yields one result.
  function automatic void absorb_request(bms_tb_pkg::text_req_t q);
    if (text_shadow.size() < bms_pkg::TEXT_DEPTH) text_shadow.push_back(q.text_byte);
    else dropped_shadow = 1'b1;
    if (q.last_byte) begin
      expected_results.push_back(search_text());
      text_shadow.delete();
      dropped_shadow = 1'b0;
    end
  endfunction

  // Driver: presents pending requests at the falling edge with random gaps.
  int send_gap = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.last_byte = 1'b0;
  end
  always @(negedge clk) begin
    if (in_took) begin
      // The request went in at the last rising edge.
      void'(pending_reqs.pop_front());
    end
    if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (rst_n && pending_reqs.size() > 0 &&
                 (!hold_sender || (in_ch.valid && !in_took))) begin
      if (in_took && $urandom_range(0, 3) == 0) begin
        send_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.text_byte <= pending_reqs[0].text_byte;
        in_ch.last_byte <= pending_reqs[0].last_byte;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver stalls: mostly short, now and then long, sometimes none at all.
  int stall_left = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  // Monitor: requests feed the predictor, results are checked in order.
  always @(posedge clk) begin
    in_took = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        absorb_request('{in_ch.text_byte, in_ch.last_byte});
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.found) found_seen++;
        if (out_ch.overflow) overflow_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result found=%0b offset=%0d overflow=%0b", $time,
                   out_ch.found, out_ch.match_offset, out_ch.overflow);
        end else begin
          automatic bms_tb_pkg::search_res_t e = expected_results.pop_front();
          if (e.found !== out_ch.found || e.match_offset !== out_ch.match_offset ||
              e.overflow !== out_ch.overflow) begin
            errors++;
            $display("%0t: mismatch expected found=%0b offset=%0d overflow=%0b, %s",
                     $time, e.found, e.match_offset, e.overflow, "actual");
            $display("%0t:   actual found=%0b offset=%0d overflow=%0b", $time,
                     out_ch.found, out_ch.match_offset, out_ch.overflow);
          end
        end
      end
    end
  end

  // Watchdog: a scan of a full store can compare every pattern byte at every
  // position, so the limit sits above that worst case.
  always @(posedge clk) begin
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000000) begin
      $display("boyer_moore_byte_search test failed");
      $finish;
    end
  end

  // Configuration writes happen only with the block idle.
  task automatic write_reg(input logic [bms_pkg::CFG_IW-1:0] idx,
                           input logic [bms_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bms_pkg::CFG_LEN) len_shadow = val[5:0];
    else pat_shadow[64*idx +: 64] = val;
  endtask

  task automatic set_pattern(input logic [8*bms_pkg::PAT_MAX-1:0] pat, input logic [5:0] len);
    write_reg(bms_pkg::CFG_PAT0, pat[63:0]);
    write_reg(bms_pkg::CFG_PAT1, pat[127:64]);
    write_reg(bms_pkg::CFG_PAT2, pat[191:128]);
    write_reg(bms_pkg::CFG_PAT3, pat[255:192]);
    write_reg(bms_pkg::CFG_LEN, {58'd0, len});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(negedge clk);
    // The block may still be finishing a scan; allow generous slack.
    repeat (3000) @(negedge clk);
  endtask

  // Queue one text; with plant set the pattern is copied in at a random place.
  task automatic queue_text(input int n, input bit plant, input int alphabet);
    logic [7:0] t[];
    int len, at;
    t = new[n];
    len = (len_shadow > bms_pkg::PAT_MAX) ? bms_pkg::PAT_MAX : len_shadow;
    for (int i = 0; i < n; i++)
      t[i] = (alphabet >= 256) ? 8'($urandom) : pat_shadow[8*$urandom_range(0, alphabet-1) +: 8];
    if (plant && len > 0 && n >= len) begin
      at = $urandom_range(0, n - len);
      for (int k = 0; k < len; k++) t[at+k] = pat_shadow[8*k +: 8];
    end
    for (int i = 0; i < n; i++) pending_reqs.push_back('{t[i], i == n - 1});
  endtask

  function automatic logic [8*bms_pkg::PAT_MAX-1:0] rand_pattern(input int alphabet);
    logic [8*bms_pkg::PAT_MAX-1:0] p;
    for (int k = 0; k < bms_pkg::PAT_MAX; k++)
      p[8*k +: 8] = (alphabet >= 256) ? 8'($urandom) : 8'($urandom_range(0, alphabet-1));
    return p;
  endfunction

  initial begin
    int long_text;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset pattern (one zero byte), single-byte and two-byte texts and extremes.
    pending_reqs.push_back('{8'h00, 1'b1});
    pending_reqs.push_back('{8'hff, 1'b1});
    pending_reqs.push_back('{8'hff, 1'b0});
    pending_reqs.push_back('{8'h00, 1'b1});
    wait_drained();
    // Full-length pattern of 0xff bytes; texts shorter than the pattern, one a single 0x55 byte, and a match.
    set_pattern({32{8'hff}}, 6'd32);
    queue_text(10, 1'b0, 256);
    pending_reqs.push_back('{8'h55, 1'b1});
    for (int i = 0; i < 32; i++) pending_reqs.push_back('{8'hff, i == 31});
    wait_drained();
    // Zero length and a length above the maximum (saturated).
    set_pattern({16{8'haa, 8'h55}}, 6'd0);
    queue_text(5, 1'b0, 256);
    wait_drained();
    write_reg(bms_pkg::CFG_LEN, 64'd63);
    queue_text(40, 1'b1, 2);
    wait_drained();
    // Unknown register indexes must be ignored by the block.
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= 3'd5; cfg_data <= '1;
    @(negedge clk);
    cfg_index <= 3'd7;
    @(negedge clk);
    cfg_we <= 1'b0;
    write_reg(bms_pkg::CFG_LEN, 64'd3);
    queue_text(12, 1'b1, 3);
    wait_drained();

    // A longer text with a random four-byte pattern planted once.
    set_pattern(rand_pattern(256), 6'd4);
    long_text = 100;
    queue_text(long_text, 1'b1, 256);
    wait_drained();

    // Random part: mostly short texts over small alphabets so matches are common.
    for (int ph = 0; ph < 90; ph++) begin
      automatic int alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
      automatic logic [5:0] len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                  : 6'($urandom_range(1, 32));
      set_pattern(rand_pattern(alpha), len);
      repeat ($urandom_range(1, 3)) begin
        queue_text($urandom_range(1, 12), $urandom_range(0, 1), alpha);
        if (ph == 45) begin
          // Sender waits until everything expected has come back.
          hold_sender = 1'b1;
          while (expected_results.size() > 0) @(negedge clk);
          repeat (20) @(negedge clk);
          hold_sender = 1'b0;
        end
      end
      wait_drained();
    end

    $display("Ran %0d searches (%0d found, %0d with dropped bytes) over many patterns.",
             results_seen, found_seen, overflow_seen);
    if (errors == 0) begin
      $display("boyer_moore_byte_search test passed");
    end else begin
      $display("boyer_moore_byte_search test failed");
    end
    $finish;
  end
endmodule

[sim.f]
src/bms_pkg.sv
src/bms_if.sv
src/bms_ram.sv
src/bms_tables.sv
src/boyer_moore_byte_search.sv
dv/bms_tb_if.sv
dv/boyer_moore_byte_search_tb.sv
